// ===== rtl/core/pcsp_pkg.sv =====
// Shared types, codes and the ESC command table for the printer command stream parser.
package pcsp_pkg;

    localparam int DefMaxParams = 3;
    localparam int ParamSlots   = 3;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_CMD    = 2'd1,
        MODE_PARAMS = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        KIND_PRINT   = 3'd0,
        KIND_TAB     = 3'd1,
        KIND_NEWLINE = 3'd2,
        KIND_PAGE    = 3'd3,
        KIND_CANCEL  = 3'd4,
        KIND_COMMAND = 3'd5,
        KIND_PAYLOAD = 3'd6,
        KIND_UNKNOWN = 3'd7
    } t_kind;

    localparam t_byte BYTE_ESC = 8'h1B;
    localparam t_byte BYTE_GS  = 8'h1D;
    localparam t_byte BYTE_DLE = 8'h10;
    localparam t_byte BYTE_FS  = 8'h1C;
    localparam t_byte BYTE_TAB = 8'h09;
    localparam t_byte BYTE_LF  = 8'h0A;
    localparam t_byte BYTE_CR  = 8'h0D;
    localparam t_byte BYTE_FF  = 8'h0C;
    localparam t_byte BYTE_CAN = 8'h18;

    typedef struct packed {
        logic       hit;
        logic [1:0] nparams;
        logic       payload;
    } t_cmd_info;

    function automatic t_cmd_info esc_lookup(input t_byte code);
        t_cmd_info info;
        info = '{hit: 1'b1, nparams: 2'd0, payload: 1'b0};
        unique case (code)
            8'h0C, 8'h32, 8'h40, 8'h4C, 8'h53, 8'h69, 8'h6D: info.nparams = 2'd0;
            8'h20, 8'h21, 8'h25, 8'h2D, 8'h33, 8'h3D, 8'h3F, 8'h45, 8'h47,
            8'h4A, 8'h4D, 8'h52, 8'h54, 8'h56, 8'h61, 8'h64, 8'h74, 8'h7B:
                info.nparams = 2'd1;
            8'h24, 8'h5C, 8'h63: info.nparams = 2'd2;
            8'h70: info.nparams = 2'd3;
            8'h26, 8'h2A: begin
                info.nparams = 2'd3;
                info.payload = 1'b1;
            end
            8'h44, 8'h57: info.payload = 1'b1;
            default: info.hit = 1'b0;
        endcase
        return info;
    endfunction

endpackage

// ===== rtl/core/printer_command_stream_parser.sv =====
// Top level of the printer command stream parser: byte classifier, command collector, output register.
// Output timing: a result appears in the output register in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; a byte is taken whenever the output register is empty or
// being taken in the same cycle, so a stalled result holds the input side until it is taken.
// Reset (synchronous, active low): parser returns to normal mode, held prefix, command and
// counts clear, output register empties; parameter slots keep their contents.
module printer_command_stream_parser
    import pcsp_pkg::*;
#(
    parameter int MAX_PARAMS = DefMaxParams
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_out_kind,
    output logic [7:0] o_out_data,
    output logic [7:0] o_out_prefix,
    output logic [7:0] o_out_command,
    output logic [1:0] o_out_param_count,
    output logic [7:0] o_out_param0,
    output logic [7:0] o_out_param1,
    output logic [7:0] o_out_param2
);

    localparam logic [1:0] ParamCap = 2'(MAX_PARAMS);

    t_mode      r_mode, n_mode;
    t_byte      r_prefix, n_prefix;
    t_byte      r_command, n_command;
    logic [1:0] r_wanted, n_wanted;
    logic [1:0] r_seen, n_seen;
    logic       r_payload, n_payload;
    t_byte      r_store [ParamSlots];
    t_byte      n_store [ParamSlots];

    logic       r_out_valid;
    t_kind      r_kind;
    t_byte      r_data, r_out_prefix, r_out_command;
    logic [1:0] r_count;
    t_byte      r_param [ParamSlots];

    logic       emit;
    t_kind      emit_kind;
    logic       accept;
    t_cmd_info  info;
    logic [1:0] capped;
    logic [2:0] seen_inc;
    logic       is_prefix;
    logic       last_param;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign info      = esc_lookup(i_in_byte);
    assign capped    = (info.nparams > ParamCap) ? ParamCap : info.nparams;
    assign seen_inc  = {1'b0, r_seen} + 3'd1;
    assign last_param = seen_inc >= {1'b0, r_wanted};
    assign is_prefix = (i_in_byte == BYTE_ESC) || (i_in_byte == BYTE_GS) ||
                       (i_in_byte == BYTE_DLE) || (i_in_byte == BYTE_FS);

    always_comb begin
        n_mode = MODE_NORMAL;
        unique case (r_mode)
            MODE_CMD: begin
                if (r_prefix == BYTE_ESC && info.hit && capped != 2'd0) begin
                    n_mode = MODE_PARAMS;
                end
            end
            MODE_PARAMS: begin
                if (!last_param) begin
                    n_mode = MODE_PARAMS;
                end
            end
            default: begin
                if (is_prefix) begin
                    n_mode = MODE_CMD;
                end
            end
        endcase
    end

    always_comb begin
        n_prefix  = r_prefix;
        n_command = r_command;
        n_wanted  = r_wanted;
        n_seen    = r_seen;
        n_payload = r_payload;
        for (int i = 0; i < ParamSlots; i++) begin
            n_store[i] = r_store[i];
        end
        emit      = 1'b0;
        emit_kind = KIND_PRINT;
        unique case (r_mode)
            MODE_CMD: begin
                n_command = i_in_byte;
                n_seen    = 2'd0;
                if (r_prefix == BYTE_ESC && info.hit) begin
                    n_wanted  = capped;
                    n_payload = info.payload;
                    emit      = (capped == 2'd0);
                    emit_kind = info.payload ? KIND_PAYLOAD : KIND_COMMAND;
                end else begin
                    n_wanted  = 2'd0;
                    n_payload = 1'b0;
                    emit      = 1'b1;
                    emit_kind = KIND_UNKNOWN;
                end
            end
            MODE_PARAMS: begin
                n_store[r_seen] = i_in_byte;
                n_seen    = seen_inc[1:0];
                emit      = last_param;
                emit_kind = r_payload ? KIND_PAYLOAD : KIND_COMMAND;
            end
            default: begin
                emit = !is_prefix;
                if (is_prefix) begin
                    n_prefix = i_in_byte;
                end
                priority if (i_in_byte == BYTE_TAB) begin
                    emit_kind = KIND_TAB;
                end else if (i_in_byte == BYTE_LF || i_in_byte == BYTE_CR) begin
                    emit_kind = KIND_NEWLINE;
                end else if (i_in_byte == BYTE_FF) begin
                    emit_kind = KIND_PAGE;
                end else if (i_in_byte == BYTE_CAN) begin
                    emit_kind = KIND_CANCEL;
                end else begin
                    emit_kind = KIND_PRINT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_prefix    <= '0;
            r_command   <= '0;
            r_wanted    <= '0;
            r_seen      <= '0;
            r_payload   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode    <= n_mode;
                r_prefix  <= n_prefix;
                r_command <= n_command;
                r_wanted  <= n_wanted;
                r_seen    <= n_seen;
                r_payload <= n_payload;
            end
            if (accept) begin
                r_out_valid <= emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < ParamSlots; i++) begin
                r_store[i] <= n_store[i];
            end
        end
        if (accept && emit) begin
            r_kind <= emit_kind;
            r_data <= (emit_kind == KIND_PRINT) ? i_in_byte : '0;
            if (emit_kind == KIND_COMMAND || emit_kind == KIND_PAYLOAD ||
                emit_kind == KIND_UNKNOWN) begin
                r_out_prefix  <= r_prefix;
                r_out_command <= n_command;
                r_count       <= n_seen;
                for (int i = 0; i < ParamSlots; i++) begin
                    r_param[i] <= (2'(i) < n_seen) ? n_store[i] : '0;
                end
            end else begin
                r_out_prefix  <= '0;
                r_out_command <= '0;
                r_count       <= '0;
                for (int i = 0; i < ParamSlots; i++) begin
                    r_param[i] <= '0;
                end
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_kind        = r_kind;
    assign o_out_data        = r_data;
    assign o_out_prefix      = r_out_prefix;
    assign o_out_command     = r_out_command;
    assign o_out_param_count = r_count;
    assign o_out_param0      = r_param[0];
    assign o_out_param1      = r_param[1];
    assign o_out_param2      = r_param[2];

`ifndef SYNTH
    a_unknown_no_params: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_UNKNOWN |-> o_out_param_count == 2'd0)
        else $error("unknown command beat carries parameters");

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_param_count <= ParamCap)
        else $error("parameter count above cap");

    a_params_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_PARAMS |-> r_wanted != 2'd0 && r_seen < r_wanted)
        else $error("parameter collection out of range");

    a_prefix_opens_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_mode != MODE_CMD && r_mode != MODE_PARAMS && is_prefix
        |=> r_mode == MODE_CMD && !r_out_valid)
        else $error("prefix byte did not open a command");

    a_print_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_PRINT |-> o_out_prefix == 8'h00 &&
        o_out_command == 8'h00)
        else $error("print beat carries command fields");
`endif

endmodule
